@@ rtl/core/kecn_pkg.sv @@
// shared constants, types and key decode for the keypad entry cache notifier
package kecn_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned DefCacheDepth = 32;
  localparam int unsigned DefPadBlock   = 16;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CfgCacheSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeout   = 2'd1;

  // register limits and reset values
  localparam logic [5:0] MinCacheSize = 6'd1;
  localparam logic [5:0] MaxCacheSize = 6'd32;
  localparam logic [5:0] DefCacheSize = 6'd4;
  localparam logic [5:0] MinTimeout   = 6'd1;
  localparam logic [5:0] MaxTimeout   = 6'd10;
  localparam logic [3:0] DefTimeout   = 4'd2;

  // input opcodes
  localparam logic OpKey  = 1'b0;
  localparam logic OpTick = 1'b1;

  // key codes
  localparam logic [4:0] KeyDigit0 = 5'd0;
  localparam logic [4:0] KeyDigit9 = 5'd9;
  localparam logic [4:0] KeyStar   = 5'd10;
  localparam logic [4:0] KeyHash   = 5'd11;
  localparam logic [4:0] KeyEnter  = 5'd12;
  localparam logic [4:0] KeyEscape = 5'd13;

  // notification header codes
  localparam logic [7:0] DtypeNone    = 8'h00;
  localparam logic [7:0] DtypeAscii   = 8'h02;
  localparam logic [7:0] EvCaching    = 8'h00;
  localparam logic [7:0] EvCachedKeys = 8'h01;
  localparam logic [7:0] EvEnter      = 8'h02;
  localparam logic [7:0] EvCancel     = 8'h1B;
  localparam logic [7:0] PadValue     = 8'hFF;

  // configuration state seen by the controller
  typedef struct packed {
    logic [5:0] cache_size;
    logic [3:0] timeout;
    logic       clear;
  } cfg_t;

  // ascii character of a digit, star or hash key
  function automatic logic [7:0] key_ascii(input logic [4:0] key);
    logic [7:0] res;
    case (key)
      KeyStar: res = 8'h2A;
      KeyHash: res = 8'h23;
      default: res = 8'h30 + {3'b000, key};
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/kecn_key_mem.sv @@
// key cache memory: one write port, one registered read port
module kecn_key_mem #(
  parameter int unsigned CACHE_DEPTH = kecn_pkg::DefCacheDepth
) (
  input  logic                                                  clk_i,
  input  logic                                                  we_i,
  input  logic [$clog2(CACHE_DEPTH > 1 ? CACHE_DEPTH : 2)-1:0] waddr_i,
  input  logic [7:0]                                            wdata_i,
  input  logic                                                  re_i,
  input  logic [$clog2(CACHE_DEPTH > 1 ? CACHE_DEPTH : 2)-1:0] raddr_i,
  output logic [7:0]                                            rdata_o
);
  import kecn_pkg::*;

  logic [7:0] mem_q [CACHE_DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/kecn_ctrl.sv @@
// key handling, timer and notification byte streamer
module kecn_ctrl #(
  parameter int unsigned CACHE_DEPTH = kecn_pkg::DefCacheDepth,
  parameter int unsigned PAD_BLOCK   = kecn_pkg::DefPadBlock
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  kecn_pkg::cfg_t                                        cfg_i,
  input  logic                                                  in_valid_i,
  output logic                                                  in_stall_o,
  input  logic                                                  opcode_i,
  input  logic [4:0]                                            key_code_i,
  output logic                                                  out_valid_o,
  input  logic                                                  out_stall_i,
  output logic [7:0]                                            out_byte_o,
  output logic                                                  last_byte_o,
  output logic                                                  mem_we_o,
  output logic [$clog2(CACHE_DEPTH > 1 ? CACHE_DEPTH : 2)-1:0] mem_waddr_o,
  output logic [7:0]                                            mem_wdata_o,
  output logic                                                  mem_re_o,
  output logic [$clog2(CACHE_DEPTH > 1 ? CACHE_DEPTH : 2)-1:0] mem_raddr_o,
  input  logic [7:0]                                            mem_rdata_i
);
  import kecn_pkg::*;

  localparam int unsigned AW = $clog2(CACHE_DEPTH > 1 ? CACHE_DEPTH : 2);
  localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);
  localparam int unsigned PW = $clog2(PAD_BLOCK > 1 ? PAD_BLOCK : 2);

  typedef enum logic [1:0] {
    StIdle,
    StHdr,
    StData
  } state_e;

  state_e        state_q, state_d;
  logic [1:0]    hidx_q, hidx_d;
  logic [7:0]    didx_q, didx_d;
  logic [7:0]    ev_q, ev_d;
  logic [CW-1:0] len_q, len_d;
  logic [7:0]    pad_q, pad_d;
  logic [7:0]    seq_q, seq_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    padded_q, padded_d;
  logic [PW-1:0] fill_q, fill_d;
  logic [3:0]    secs_q, secs_d;
  logic          armed_q, armed_d;
  logic          ov_q, ov_d;
  logic [7:0]    ob_q, ob_d;
  logic          ol_q, ol_d;

  logic          load;
  logic [CW-1:0] cnt_inc;
  logic          cnt_full;
  logic          size_hit;
  logic [7:0]    pad_add;
  logic [PW-1:0] fill_inc;
  logic [3:0]    secs_dec;
  logic [7:0]    didx_nx;

  // derived values used when an item is taken
  always_comb begin
    cnt_inc  = cnt_q + CW'(1);
    cnt_full = (cnt_q == CW'(CACHE_DEPTH));
    size_hit = (8'(cnt_inc) >= 8'(cfg_i.cache_size));
    pad_add  = (fill_q == '0) ? (padded_q + 8'(PAD_BLOCK)) : padded_q;
    fill_inc = (fill_q == PW'(PAD_BLOCK - 1)) ? '0 : (fill_q + PW'(1));
    secs_dec = (secs_q != 4'd0) ? (secs_q - 4'd1) : 4'd0;
    didx_nx  = didx_q + 8'd1;
    load     = !ov_q || !out_stall_i;
  end

  // next state
  always_comb begin
    state_d  = state_q;
    hidx_d   = hidx_q;
    didx_d   = didx_q;
    ev_d     = ev_q;
    len_d    = len_q;
    pad_d    = pad_q;
    seq_d    = seq_q;
    cnt_d    = cnt_q;
    padded_d = padded_q;
    fill_d   = fill_q;
    secs_d   = secs_q;
    armed_d  = armed_q;
    ov_d     = ov_q;
    ob_d     = ob_q;
    ol_d     = ol_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[AW-1:0];
    mem_wdata_o = key_ascii(key_code_i);
    mem_re_o    = 1'b0;
    mem_raddr_o = didx_nx[AW-1:0];

    // output transaction taken
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (opcode_i == OpTick) begin
            // one-second tick runs the one-shot timer
            if (armed_q) begin
              secs_d = secs_dec;
              if (secs_dec == 4'd0) begin
                armed_d = 1'b0;
                if (cnt_q != '0) begin
                  state_d  = StHdr;
                  hidx_d   = 2'd0;
                  ev_d     = EvCachedKeys;
                  len_d    = cnt_q;
                  pad_d    = padded_q;
                  cnt_d    = '0;
                  padded_d = '0;
                  fill_d   = '0;
                  secs_d   = 4'd0;
                end
              end
            end
          end else begin
            case (key_code_i) inside
              [KeyDigit0:KeyHash]: begin
                // caching notice when the first key arrives, unless the cache size is one
                if (cnt_q == '0 && cfg_i.cache_size > 6'd1) begin
                  state_d = StHdr;
                  hidx_d  = 2'd0;
                  ev_d    = EvCaching;
                  len_d   = '0;
                  pad_d   = 8'd0;
                end
                if (!cnt_full) begin
                  mem_we_o = 1'b1;
                  if (size_hit) begin
                    // cache reached its size: flush with data
                    state_d  = StHdr;
                    hidx_d   = 2'd0;
                    ev_d     = EvCachedKeys;
                    len_d    = cnt_inc;
                    pad_d    = pad_add;
                    cnt_d    = '0;
                    padded_d = '0;
                    fill_d   = '0;
                    secs_d   = 4'd0;
                    armed_d  = 1'b0;
                  end else begin
                    cnt_d    = cnt_inc;
                    padded_d = pad_add;
                    fill_d   = fill_inc;
                    secs_d   = cfg_i.timeout;
                    armed_d  = 1'b1;
                  end
                end
              end
              KeyEnter, KeyEscape: begin
                state_d  = StHdr;
                hidx_d   = 2'd0;
                ev_d     = (key_code_i == KeyEnter) ? EvEnter : EvCancel;
                len_d    = cnt_q;
                pad_d    = padded_q;
                cnt_d    = '0;
                padded_d = '0;
                fill_d   = '0;
                secs_d   = 4'd0;
                armed_d  = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end

      StHdr: begin
        // four header bytes
        if (load) begin
          ov_d   = 1'b1;
          ol_d   = (hidx_q == 2'd3) && (pad_q == 8'd0);
          hidx_d = hidx_q + 2'd1;
          case (hidx_q)
            2'd0: begin
              ob_d  = seq_q;
              seq_d = seq_q + 8'd1;
            end
            2'd1:    ob_d = (pad_q != 8'd0) ? DtypeAscii : DtypeNone;
            2'd2:    ob_d = ev_q;
            default: ob_d = pad_q;
          endcase
          if (hidx_q == 2'd3) begin
            if (pad_q == 8'd0) begin
              state_d = StIdle;
            end else begin
              state_d     = StData;
              didx_d      = 8'd0;
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
            end
          end
        end
      end

      StData: begin
        // cached keys then padding, next entry read ahead
        if (load) begin
          ov_d = 1'b1;
          ob_d = (didx_q < 8'(len_q)) ? mem_rdata_i : PadValue;
          ol_d = (didx_nx == pad_q);
          if (didx_nx == pad_q) begin
            state_d = StIdle;
          end else begin
            didx_d   = didx_nx;
            mem_re_o = 1'b1;
          end
        end
      end

      default: state_d = StIdle;
    endcase

    // valid configuration write empties the cache and stops the timer
    if (cfg_i.clear) begin
      cnt_d    = '0;
      padded_d = '0;
      fill_d   = '0;
      secs_d   = 4'd0;
      armed_d  = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      hidx_q   <= 2'd0;
      didx_q   <= 8'd0;
      ev_q     <= 8'd0;
      len_q    <= '0;
      pad_q    <= 8'd0;
      seq_q    <= 8'd0;
      cnt_q    <= '0;
      padded_q <= 8'd0;
      fill_q   <= '0;
      secs_q   <= 4'd0;
      armed_q  <= 1'b0;
      ov_q     <= 1'b0;
      ob_q     <= 8'd0;
      ol_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      hidx_q   <= hidx_d;
      didx_q   <= didx_d;
      ev_q     <= ev_d;
      len_q    <= len_d;
      pad_q    <= pad_d;
      seq_q    <= seq_d;
      cnt_q    <= cnt_d;
      padded_q <= padded_d;
      fill_q   <= fill_d;
      secs_q   <= secs_d;
      armed_q  <= armed_d;
      ov_q     <= ov_d;
      ob_q     <= ob_d;
      ol_q     <= ol_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign last_byte_o = ol_q;

endmodule

@@ rtl/core/keypad_entry_cache_notifier_unit.sv @@
// top level: configuration registers, controller and key cache memory
//
// Keypad entry cache notifier. Digit, star and hash keys are stored as ascii
// in a single-port-read cache memory; enter, escape, a full cache or the
// one-shot timer (counted in tick transactions) flush it as a notification
// streamed one byte per output transaction: sequence number, data type, event
// type, padded length, then the keys padded with 0xFF to a multiple of
// PAD_BLOCK. Input transactions are taken one at a time, and the input is
// stalled while a notification is streamed. The streamer emits one byte per
// cycle and reads one cache entry per cycle from the memory read port, both
// only while the output is not stalled. The last byte may still wait in the
// output register while the next item is taken. Configuration writes are
// always ready; a legal write empties the cache and stops the timer, an
// out-of-range value or unknown index is ignored.
module keypad_entry_cache_notifier_unit #(
  parameter int unsigned CACHE_DEPTH = kecn_pkg::DefCacheDepth,
  parameter int unsigned PAD_BLOCK   = kecn_pkg::DefPadBlock
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [4:0]                      key_code_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            last_byte_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kecn_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [kecn_pkg::CfgDataW-1:0]   cfg_data_i
);
  import kecn_pkg::*;

  localparam int unsigned AW = $clog2(CACHE_DEPTH > 1 ? CACHE_DEPTH : 2);

  logic [5:0]    cache_size_q;
  logic [3:0]    timeout_q;
  logic          cfg_clear;
  cfg_t          cfg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  // legal configuration writes
  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCacheSize:
          cfg_clear = (cfg_data_i >= MinCacheSize) && (cfg_data_i <= MaxCacheSize);
        CfgTimeout:
          cfg_clear = (cfg_data_i >= MinTimeout) && (cfg_data_i <= MaxTimeout);
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_size_q <= DefCacheSize;
      timeout_q    <= DefTimeout;
    end else if (cfg_clear) begin
      if (cfg_index_i == CfgCacheSize) begin
        cache_size_q <= cfg_data_i;
      end else begin
        timeout_q <= cfg_data_i[3:0];
      end
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign cfg.cache_size = cache_size_q;
  assign cfg.timeout    = timeout_q;
  assign cfg.clear      = cfg_clear;

  kecn_ctrl #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .PAD_BLOCK   (PAD_BLOCK)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .key_code_i  (key_code_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  kecn_key_mem #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
